@@ src/bqf_pkg.sv @@
// Shared types, constants and the per-form micro-program of the four-lane biquad filter.
`timescale 1ns / 1ps

package bqf_pkg;

    // Defaults for the top-level parameters
    localparam int LANES_DEF          = 4;
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 21;

    // Fixed widths
    localparam int COEF_W    = 24;     // coefficient registers, signed Q2.x
    localparam int STATE_W   = 32;     // per-lane delay states
    localparam int ACC_W     = 64;     // product and accumulator width
    localparam int PC_W      = 4;      // micro-program counter
    localparam int CFG_IDX_W = 3;

    localparam logic signed [COEF_W-1:0] COEF_A0_RST = 24'sd2097152;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FORM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_A1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_B1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_B2   = 3'd5;

    typedef enum logic [1:0] {
        FORM_DIRECT = 2'd0,
        FORM_CANON  = 2'd1,
        FORM_TDIRECT = 2'd2,
        FORM_TCANON = 2'd3
    } t_form;

    typedef struct packed {
        logic [COEF_W-1:0] a0;
        logic [COEF_W-1:0] a1;
        logic [COEF_W-1:0] a2;
        logic [COEF_W-1:0] b1;
        logic [COEF_W-1:0] b2;
    } t_coefs;

    // Lane handshake with the top level
    typedef struct packed {
        logic start;
        logic take;
    } t_lane_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_lane_stat;

    // Micro-op fields
    typedef enum logic [1:0] {
        K_MAC  = 2'd0,   // product (or lifted operand) into r_prod, then accumulate
        K_FIN  = 2'd1,   // round, saturate, write destination
        K_WSUM = 2'd2,   // w = sat32(x + yd1)
        K_END  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        C_A0 = 3'd0, C_A1 = 3'd1, C_A2 = 3'd2, C_B1 = 3'd3, C_B2 = 3'd4
    } t_csel;

    typedef enum logic [2:0] {
        O_X = 3'd0, O_XD1 = 3'd1, O_XD2 = 3'd2, O_YD1 = 3'd3,
        O_YD2 = 3'd4, O_W = 3'd5, O_Y = 3'd6
    } t_osel;

    typedef enum logic [2:0] {
        D_Y_DIRECT = 3'd0,  // y, plus shift of both delay lines
        D_Y_CANON  = 3'd1,  // y, plus shift of w into the input delays
        D_Y        = 3'd2,
        D_W        = 3'd3,
        D_OD1      = 3'd4,
        D_OD2      = 3'd5,
        D_ID1      = 3'd6,
        D_ID2      = 3'd7
    } t_dest;

    typedef struct packed {
        t_kind kind;
        logic  first;   // start a new sum with the rounding half
        t_csel coef;
        t_osel opnd;
        logic  neg;
        logic  lift;    // operand scaled by 2^frac instead of multiplied
        t_dest dest;
    } t_uop;

    function automatic t_uop op_mac(input logic first, input t_csel c, input t_osel o,
                                    input logic neg);
        t_uop u;
        u = '{kind: K_MAC, first: first, coef: c, opnd: o, neg: neg, lift: 1'b0,
              dest: D_Y};
        return u;
    endfunction

    function automatic t_uop op_lift(input logic first, input t_osel o);
        t_uop u;
        u = '{kind: K_MAC, first: first, coef: C_A0, opnd: o, neg: 1'b0, lift: 1'b1,
              dest: D_Y};
        return u;
    endfunction

    function automatic t_uop op_fin(input t_dest d);
        t_uop u;
        u = '{kind: K_FIN, first: 1'b0, coef: C_A0, opnd: O_X, neg: 1'b0, lift: 1'b0,
              dest: d};
        return u;
    endfunction

    function automatic t_uop op_ctl(input t_kind k);
        t_uop u;
        u = '{kind: k, first: 1'b0, coef: C_A0, opnd: O_X, neg: 1'b0, lift: 1'b0,
              dest: D_Y};
        return u;
    endfunction

    // Micro-program: one entry per step, per filter form
    function automatic t_uop uop_at(input t_form form, input logic [PC_W-1:0] pc);
        t_uop u;
        u = op_ctl(K_END);
        case (form)
            FORM_DIRECT: begin
                case (pc)
                    4'd0: u = op_mac(1'b1, C_A0, O_X,   1'b0);
                    4'd1: u = op_mac(1'b0, C_A1, O_XD1, 1'b0);
                    4'd2: u = op_mac(1'b0, C_A2, O_XD2, 1'b0);
                    4'd3: u = op_mac(1'b0, C_B1, O_YD1, 1'b1);
                    4'd4: u = op_mac(1'b0, C_B2, O_YD2, 1'b1);
                    4'd5: u = op_fin(D_Y_DIRECT);
                    default: u = op_ctl(K_END);
                endcase
            end
            FORM_CANON: begin
                case (pc)
                    4'd0: u = op_lift(1'b1, O_X);
                    4'd1: u = op_mac(1'b0, C_B1, O_XD1, 1'b1);
                    4'd2: u = op_mac(1'b0, C_B2, O_XD2, 1'b1);
                    4'd3: u = op_fin(D_W);
                    4'd4: u = op_mac(1'b1, C_A0, O_W,   1'b0);
                    4'd5: u = op_mac(1'b0, C_A1, O_XD1, 1'b0);
                    4'd6: u = op_mac(1'b0, C_A2, O_XD2, 1'b0);
                    4'd7: u = op_fin(D_Y_CANON);
                    default: u = op_ctl(K_END);
                endcase
            end
            FORM_TDIRECT: begin
                // in-place updates are ordered so every sum still sees old values
                case (pc)
                    4'd0:  u = op_ctl(K_WSUM);
                    4'd1:  u = op_mac(1'b1, C_A0, O_W, 1'b0);
                    4'd2:  u = op_lift(1'b0, O_XD1);
                    4'd3:  u = op_fin(D_Y);
                    4'd4:  u = op_lift(1'b1, O_YD2);
                    4'd5:  u = op_mac(1'b0, C_B1, O_W, 1'b1);
                    4'd6:  u = op_fin(D_OD1);
                    4'd7:  u = op_mac(1'b1, C_B2, O_W, 1'b1);
                    4'd8:  u = op_fin(D_OD2);
                    4'd9:  u = op_lift(1'b1, O_XD2);
                    4'd10: u = op_mac(1'b0, C_A1, O_W, 1'b0);
                    4'd11: u = op_fin(D_ID1);
                    4'd12: u = op_mac(1'b1, C_A2, O_W, 1'b0);
                    4'd13: u = op_fin(D_ID2);
                    default: u = op_ctl(K_END);
                endcase
            end
            FORM_TCANON: begin
                case (pc)
                    4'd0: u = op_mac(1'b1, C_A0, O_X, 1'b0);
                    4'd1: u = op_lift(1'b0, O_XD1);
                    4'd2: u = op_fin(D_Y);
                    4'd3: u = op_mac(1'b1, C_A1, O_X, 1'b0);
                    4'd4: u = op_mac(1'b0, C_B1, O_Y, 1'b1);
                    4'd5: u = op_lift(1'b0, O_XD2);
                    4'd6: u = op_fin(D_ID1);
                    4'd7: u = op_mac(1'b1, C_A2, O_X, 1'b0);
                    4'd8: u = op_mac(1'b0, C_B2, O_Y, 1'b1);
                    4'd9: u = op_fin(D_ID2);
                    default: u = op_ctl(K_END);
                endcase
            end
            default: u = op_ctl(K_END);
        endcase
        return u;
    endfunction

endpackage

@@ src/bqf_lane.sv @@
// One filter lane: delay states, a shared multiplier and accumulator run by a micro-program.
`timescale 1ns / 1ps

module bqf_lane #(
    parameter int SAMPLE_BITS    = bqf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bqf_pkg::t_lane_ctl     i_ctl,
    input  bqf_pkg::t_form         i_form,
    input  bqf_pkg::t_coefs        i_coefs,
    input  logic [SAMPLE_BITS-1:0] i_x,
    output bqf_pkg::t_lane_stat    o_stat,
    output logic [SAMPLE_BITS-1:0] o_y
);
    import bqf_pkg::*;

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_RUN  = 4'b0010,
        L_ACC  = 4'b0100,
        L_DONE = 4'b1000
    } t_lstate;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SMP_MAX  = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SMP_MIN  = ~SMP_MAX;
    localparam logic signed [ACC_W-1:0] ST_MAX   = (ACC_W'(1) << (STATE_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] ST_MIN   = ~ST_MAX;
    localparam logic signed [STATE_W-1:0] W_MAX  = STATE_W'(ST_MAX);
    localparam logic signed [STATE_W-1:0] W_MIN  = STATE_W'(ST_MIN);

    t_lstate r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;

    logic signed [STATE_W-1:0] r_xd1, r_xd2, r_yd1, r_yd2;
    logic signed [STATE_W-1:0] r_w;
    logic signed [SAMPLE_BITS-1:0] r_x, r_y;
    logic signed [ACC_W-1:0] r_prod, r_acc;

    t_uop uop;
    logic signed [COEF_W-1:0]         coef_s;
    logic signed [STATE_W-1:0]        op_s;
    logic signed [STATE_W-1:0]        x_ext, y_ext;
    logic signed [COEF_W+STATE_W-1:0] mul;
    logic signed [ACC_W-1:0]          term, acc_base, n_acc, shifted;
    logic signed [STATE_W-1:0]        fin_res;
    logic                             to_sample;
    logic signed [STATE_W:0]          wsum;
    logic signed [STATE_W-1:0]        w_sat;

    assign uop   = uop_at(i_form, r_pc);
    assign x_ext = STATE_W'(r_x);
    assign y_ext = STATE_W'(r_y);

    always_comb begin
        case (uop.coef)
            C_A0:    coef_s = $signed(i_coefs.a0);
            C_A1:    coef_s = $signed(i_coefs.a1);
            C_A2:    coef_s = $signed(i_coefs.a2);
            C_B1:    coef_s = $signed(i_coefs.b1);
            C_B2:    coef_s = $signed(i_coefs.b2);
            default: coef_s = $signed(i_coefs.a0);
        endcase
    end

    always_comb begin
        case (uop.opnd)
            O_X:     op_s = x_ext;
            O_XD1:   op_s = r_xd1;
            O_XD2:   op_s = r_xd2;
            O_YD1:   op_s = r_yd1;
            O_YD2:   op_s = r_yd2;
            O_W:     op_s = r_w;
            O_Y:     op_s = y_ext;
            default: op_s = x_ext;
        endcase
    end

    assign mul  = coef_s * op_s;
    assign term = uop.lift ? (ACC_W'(op_s) <<< COEF_FRAC_BITS) : ACC_W'(mul);

    assign acc_base = uop.first ? RND_HALF : r_acc;
    assign n_acc    = uop.neg ? (acc_base - r_prod) : (acc_base + r_prod);

    // rounding half was added up front, so a floor shift finishes it
    assign shifted   = r_acc >>> COEF_FRAC_BITS;
    assign to_sample = (uop.dest == D_Y_DIRECT) || (uop.dest == D_Y_CANON) ||
                       (uop.dest == D_Y);

    always_comb begin
        if (to_sample) begin
            if (shifted > SMP_MAX)      fin_res = STATE_W'(SMP_MAX);
            else if (shifted < SMP_MIN) fin_res = STATE_W'(SMP_MIN);
            else                        fin_res = STATE_W'(shifted);
        end else begin
            if (shifted > ST_MAX)       fin_res = W_MAX;
            else if (shifted < ST_MIN)  fin_res = W_MIN;
            else                        fin_res = STATE_W'(shifted);
        end
    end

    assign wsum  = (STATE_W+1)'(x_ext) + (STATE_W+1)'(r_yd1);
    assign w_sat = (wsum[STATE_W] != wsum[STATE_W-1]) ?
                   (wsum[STATE_W] ? W_MIN : W_MAX) : wsum[STATE_W-1:0];

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        case (r_state)
            L_IDLE: begin
                if (i_ctl.start) begin
                    n_state = L_RUN;
                    n_pc    = '0;
                end
            end
            L_RUN: begin
                case (uop.kind)
                    K_MAC:   n_state = L_ACC;
                    K_FIN:   n_pc    = r_pc + 1'b1;
                    K_WSUM:  n_pc    = r_pc + 1'b1;
                    K_END:   n_state = L_DONE;
                    default: n_state = L_DONE;
                endcase
            end
            L_ACC: begin
                n_pc    = r_pc + 1'b1;
                n_state = L_RUN;
            end
            L_DONE: begin
                if (i_ctl.take) n_state = L_IDLE;
            end
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_pc    <= '0;
            r_xd1   <= '0;
            r_xd2   <= '0;
            r_yd1   <= '0;
            r_yd2   <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            if (r_state == L_RUN && uop.kind == K_FIN) begin
                case (uop.dest)
                    D_Y_DIRECT: begin
                        r_xd2 <= r_xd1;
                        r_xd1 <= x_ext;
                        r_yd2 <= r_yd1;
                        r_yd1 <= fin_res;
                    end
                    D_Y_CANON: begin
                        r_xd2 <= r_xd1;
                        r_xd1 <= r_w;
                    end
                    D_OD1:   r_yd1 <= fin_res;
                    D_OD2:   r_yd2 <= fin_res;
                    D_ID1:   r_xd1 <= fin_res;
                    D_ID2:   r_xd2 <= fin_res;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == L_IDLE && i_ctl.start) r_x <= i_x;
        if (r_state == L_RUN && uop.kind == K_MAC) r_prod <= term;
        if (r_state == L_ACC) r_acc <= n_acc;
        if (r_state == L_RUN && uop.kind == K_WSUM) r_w <= w_sat;
        if (r_state == L_RUN && uop.kind == K_FIN) begin
            if (uop.dest == D_W) r_w <= fin_res;
            if (to_sample) r_y <= fin_res[SAMPLE_BITS-1:0];
        end
    end

    assign o_stat.idle = (r_state == L_IDLE);
    assign o_stat.done = (r_state == L_DONE);
    assign o_y         = r_y;

endmodule

@@ src/bqf_merge.sv @@
// Merge stage: collects the finished lane samples into the output register.
`timescale 1ns / 1ps

module bqf_merge #(
    parameter int LANES       = bqf_pkg::LANES_DEF,
    parameter int SAMPLE_BITS = bqf_pkg::SAMPLE_BITS_DEF,
    parameter int DATA_W      = ((LANES * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [LANES-1:0]                      i_done,
    input  logic [LANES-1:0][SAMPLE_BITS-1:0]     i_y,
    output logic                                  o_take,
    output logic                                  o_tvalid,
    input  logic                                  i_tready,
    output logic [DATA_W-1:0]                     o_tdata
);
    import bqf_pkg::*;

    logic                              r_valid, n_valid;
    logic [LANES-1:0][SAMPLE_BITS-1:0] r_data;
    logic                              load;

    assign load = (&i_done) && (!r_valid || i_tready);

    always_comb begin
        n_valid = r_valid;
        if (load)          n_valid = 1'b1;
        else if (i_tready) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= n_valid;
    end

    always_ff @(posedge i_clk) begin
        if (load) r_data <= i_y;
    end

    assign o_take   = load;
    assign o_tvalid = r_valid;
    assign o_tdata  = DATA_W'(r_data);

endmodule

@@ src/four_lane_biquad_filter.sv @@
// Top level of the four-lane biquad filter: configuration registers, lanes and merge stage.
`timescale 1ns / 1ps

// Multi-lane second-order IIR section. Each request on the slave stream carries one
// signed sample per lane in s_axis_tdata; the block answers with one request on the
// master stream carrying the filtered, saturated sample of every lane.
// The configuration port writes filter_form (index 0) and coefficients a0, a1, a2,
// b1, b2 (indexes 1-5, signed Q2.COEF_FRAC_BITS); other indexes are ignored. Write it
// only while the block is idle.
// Each lane owns one multiplier and one accumulator stepped by a micro-program: each
// product is registered, then added into the accumulator; all lanes run in lockstep.
// Output tvalid is registered once every lane has finished and the output
// register is empty or being read; a new request is taken as soon as the lanes
// have handed their result to the output register. If the receiver stalls, the
// result waits in the output register and the lanes may finish one further
// request and hold it; tready then stays low.
// Reset clears all delay states, selects the direct form and sets a0 = 1.0,
// other coefficients 0.
module four_lane_biquad_filter #(
    parameter int LANES          = bqf_pkg::LANES_DEF,
    parameter int SAMPLE_BITS    = bqf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF,
    parameter int DATA_W         = ((LANES * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_wr_en,
    input  logic [bqf_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [bqf_pkg::COEF_W-1:0]     i_cfg_wdata,
    // slave stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // sample_lane0, sample_lane1, ... from bit 0 up, zero padded
    input  logic [DATA_W-1:0]              i_s_axis_tdata,
    // master stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // filtered_lane0, filtered_lane1, ... from bit 0 up, zero padded
    output logic [DATA_W-1:0]              o_m_axis_tdata
);
    import bqf_pkg::*;

    t_form  r_form;
    t_coefs r_coefs;

    t_lane_ctl                         lane_ctl;
    t_lane_stat [LANES-1:0]            lane_stat;
    logic [LANES-1:0]                  lane_idle, lane_done;
    logic [LANES-1:0][SAMPLE_BITS-1:0] lane_y;
    logic                              take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_form     <= FORM_DIRECT;
            r_coefs.a0 <= COEF_A0_RST;
            r_coefs.a1 <= '0;
            r_coefs.a2 <= '0;
            r_coefs.b1 <= '0;
            r_coefs.b2 <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_FORM: r_form     <= t_form'(i_cfg_wdata[1:0]);
                CFG_A0:   r_coefs.a0 <= i_cfg_wdata;
                CFG_A1:   r_coefs.a1 <= i_cfg_wdata;
                CFG_A2:   r_coefs.a2 <= i_cfg_wdata;
                CFG_B1:   r_coefs.b1 <= i_cfg_wdata;
                CFG_B2:   r_coefs.b2 <= i_cfg_wdata;
                default:  ;
            endcase
        end
    end

    // all lanes start together; accept only when every lane is free
    assign o_s_axis_tready = &lane_idle;
    assign lane_ctl.start  = i_s_axis_tvalid && o_s_axis_tready;
    assign lane_ctl.take   = take;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        bqf_lane #(
            .SAMPLE_BITS    (SAMPLE_BITS),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_form  (r_form),
            .i_coefs (r_coefs),
            .i_x     (i_s_axis_tdata[k*SAMPLE_BITS +: SAMPLE_BITS]),
            .o_stat  (lane_stat[k]),
            .o_y     (lane_y[k])
        );
        assign lane_idle[k] = lane_stat[k].idle;
        assign lane_done[k] = lane_stat[k].done;
    end

    bqf_merge #(
        .LANES       (LANES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .DATA_W      (DATA_W)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_done   (lane_done),
        .i_y      (lane_y),
        .o_take   (take),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata)
    );

endmodule
